### hw/rtl/utf8v_pkg.sv
// ============================================================================
// utf8v_pkg
// Shared types and byte constants for the streaming strict UTF-8 checker.
// ============================================================================
`default_nettype none

package utf8v_pkg;

    // Width of one string byte on the input stream.
    localparam int unsigned ByteW = 8;

    // Allowed range for the next continuation byte.
    typedef enum logic [2:0] {
        CLS_ANY  = 3'd0,  // 80..BF
        CLS_E0   = 3'd1,  // A0..BF
        CLS_ED   = 3'd2,  // 80..9F
        CLS_F0   = 3'd3,  // 90..BF
        CLS_F4   = 3'd4   // 80..8F
    } cont_cls_t;

    // Byte values used by the terminator, single-byte, lead and continuation checks.
    localparam logic [ByteW-1:0] BYTE_NUL   = 8'h00;
    localparam logic [ByteW-1:0] BYTE_TAB   = 8'h09;
    localparam logic [ByteW-1:0] BYTE_LF    = 8'h0A;
    localparam logic [ByteW-1:0] BYTE_CR    = 8'h0D;
    localparam logic [ByteW-1:0] BYTE_SPACE = 8'h20;
    localparam logic [ByteW-1:0] BYTE_TILDE = 8'h7E;
    localparam logic [ByteW-1:0] CONT_LO    = 8'h80;
    localparam logic [ByteW-1:0] CONT_8F    = 8'h8F;
    localparam logic [ByteW-1:0] CONT_90    = 8'h90;
    localparam logic [ByteW-1:0] CONT_9F    = 8'h9F;
    localparam logic [ByteW-1:0] CONT_A0    = 8'hA0;
    localparam logic [ByteW-1:0] CONT_HI    = 8'hBF;
    localparam logic [ByteW-1:0] LEAD2_LO   = 8'hC2;
    localparam logic [ByteW-1:0] LEAD2_HI   = 8'hDF;
    localparam logic [ByteW-1:0] LEAD_E0    = 8'hE0;
    localparam logic [ByteW-1:0] LEAD_ED    = 8'hED;
    localparam logic [ByteW-1:0] LEAD3_HI   = 8'hEF;
    localparam logic [ByteW-1:0] LEAD_F0    = 8'hF0;
    localparam logic [ByteW-1:0] LEAD_F4    = 8'hF4;

    // Continuation byte check against the range selected by a class.
    function automatic logic cont_ok(input logic [ByteW-1:0] b, input cont_cls_t cls);
        logic ok;
        begin
            case (cls)
                CLS_E0:  ok = (b >= CONT_A0) && (b <= CONT_HI);
                CLS_ED:  ok = (b >= CONT_LO) && (b <= CONT_9F);
                CLS_F0:  ok = (b >= CONT_90) && (b <= CONT_HI);
                CLS_F4:  ok = (b >= CONT_LO) && (b <= CONT_8F);
                default: ok = (b >= CONT_LO) && (b <= CONT_HI);
            endcase
            return ok;
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/utf8_validator_stream_top.sv
// A terminating zero word passes the input register and then the verdict register before its
// verdict shows on m_tdata; a verdict still waiting for m_tready holds it back.
// Throughput: one byte word per cycle unless a terminator faces a waiting verdict; the input register
// and the verdict register let a new word enter while a verdict still waits for m_tready.
// The per-byte range checks and the small state update sit between those two registers.
// Reset: synchronous, active low; clears both registers' valid flags and the checker state.
// ============================================================================
// utf8_validator_stream_top
// Streaming strict UTF-8 checker: one byte per word, one verdict per string.
// ============================================================================
`default_nettype none

module utf8_validator_stream_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] is_valid, [7:1] zero
);

    // Input register.
    logic                              in_valid_reg, in_valid_next;
    logic [utf8v_pkg::ByteW-1:0]       in_byte_reg;

    // Checker state.
    logic [1:0]                        expect_reg, expect_next;
    utf8v_pkg::cont_cls_t              cls_reg, cls_next;
    logic                              err_reg, err_next;

    // Verdict register.
    logic                              out_valid_reg, out_valid_next;
    logic                              out_ok_reg, out_ok_next;

    logic in_adv;
    logic in_is_nul;
    logic b_single;

    // The held word moves on unless it is a terminator facing a full verdict slot that the sink is not taking.
    assign in_is_nul = (in_byte_reg == utf8v_pkg::BYTE_NUL);
    assign in_adv    = in_valid_reg && (!in_is_nul || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || in_adv;

    assign in_valid_next = s_tvalid && s_tready ? 1'b1 : (in_adv ? 1'b0 : in_valid_reg);

    // Printable ASCII and the allowed control bytes.
    assign b_single = (in_byte_reg == utf8v_pkg::BYTE_TAB)
                   || (in_byte_reg == utf8v_pkg::BYTE_LF)
                   || (in_byte_reg == utf8v_pkg::BYTE_CR)
                   || ((in_byte_reg >= utf8v_pkg::BYTE_SPACE)
                       && (in_byte_reg <= utf8v_pkg::BYTE_TILDE));

    // Checker state update for the word leaving the input register.
    always_comb begin
        expect_next = expect_reg;
        cls_next    = cls_reg;
        err_next    = err_reg;
        if (in_adv) begin
            if (in_is_nul) begin
                expect_next = 2'd0;
                cls_next    = utf8v_pkg::CLS_ANY;
                err_next    = 1'b0;
            end else if (err_reg) begin
                // Bytes after an error are ignored until the terminator.
                expect_next = expect_reg;
            end else if (expect_reg != 2'd0) begin
                cls_next = utf8v_pkg::CLS_ANY;
                if (utf8v_pkg::cont_ok(in_byte_reg, cls_reg)) begin
                    expect_next = expect_reg - 2'd1;
                end else begin
                    expect_next = 2'd0;
                    err_next    = 1'b1;
                end
            end else if (b_single) begin
                expect_next = 2'd0;
            end else if ((in_byte_reg >= utf8v_pkg::LEAD2_LO)
                         && (in_byte_reg <= utf8v_pkg::LEAD2_HI)) begin
                expect_next = 2'd1;
                cls_next    = utf8v_pkg::CLS_ANY;
            end else if (in_byte_reg == utf8v_pkg::LEAD_E0) begin
                expect_next = 2'd2;
                cls_next    = utf8v_pkg::CLS_E0;
            end else if (in_byte_reg == utf8v_pkg::LEAD_ED) begin
                expect_next = 2'd2;
                cls_next    = utf8v_pkg::CLS_ED;
            end else if ((in_byte_reg > utf8v_pkg::LEAD_E0)
                         && (in_byte_reg <= utf8v_pkg::LEAD3_HI)) begin
                expect_next = 2'd2;
                cls_next    = utf8v_pkg::CLS_ANY;
            end else if (in_byte_reg == utf8v_pkg::LEAD_F0) begin
                expect_next = 2'd3;
                cls_next    = utf8v_pkg::CLS_F0;
            end else if (in_byte_reg == utf8v_pkg::LEAD_F4) begin
                expect_next = 2'd3;
                cls_next    = utf8v_pkg::CLS_F4;
            end else if ((in_byte_reg > utf8v_pkg::LEAD_F0)
                         && (in_byte_reg < utf8v_pkg::LEAD_F4)) begin
                expect_next = 2'd3;
                cls_next    = utf8v_pkg::CLS_ANY;
            end else begin
                err_next = 1'b1;
            end
        end
    end

    // Verdict slot: loaded by a terminator, emptied when the sink takes it.
    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_ok_next    = out_ok_reg;
        if (in_adv && in_is_nul) begin
            out_valid_next = 1'b1;
            out_ok_next    = !err_reg && (expect_reg == 2'd0);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            expect_reg    <= 2'd0;
            cls_reg       <= utf8v_pkg::CLS_ANY;
            err_reg       <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            expect_reg    <= expect_next;
            cls_reg       <= cls_next;
            err_reg       <= err_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        out_ok_reg <= out_ok_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_ok_reg};

    // An error always leaves no open sequence behind.
    a_err_no_open: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg |-> (expect_reg == 2'd0))
        else $error("error flag set with a sequence still open");

    // A restricted second-byte class only exists with the matching bytes owed.
    a_cls_expect: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cls_reg == utf8v_pkg::CLS_E0) || (cls_reg == utf8v_pkg::CLS_ED)) |->
            (expect_reg == 2'd2))
        else $error("three-byte class without two bytes owed");

    a_cls_expect4: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cls_reg == utf8v_pkg::CLS_F0) || (cls_reg == utf8v_pkg::CLS_F4)) |->
            (expect_reg == 2'd3))
        else $error("four-byte class without three bytes owed");

    // A terminator leaves the checker idle and the verdict slot full.
    a_nul_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_adv && in_is_nul) |=> (m_tvalid && !err_reg && (expect_reg == 2'd0)
                                   && (cls_reg == utf8v_pkg::CLS_ANY)))
        else $error("terminator did not clear state or load a verdict");

endmodule

`default_nettype wire
